// ===== sv/bf2b_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and the normalized power-of-five table for the
// decimal float to binary64 converter. Depends on nothing.
package bf2b_pkg;

    localparam int S_W       = 21;   // binary significand, 15 * 111111 < 2^21
    localparam int F_W       = 162;  // normalized power of five, MSB at bit 161
    localparam int P_W       = 183;  // exact product and divisor width
    localparam int R_W       = 184;  // partial remainder width
    localparam int Q_W       = 56;   // quotient bits, quotient in [2^54, 2^56)
    localparam int E_W       = 11;   // signed binary exponent of the quotient
    localparam int POW_N     = 70;   // powers 5^0 .. 5^69
    localparam int MUL_STEPS = S_W;
    localparam int DIV_STEPS = Q_W;
    localparam int N_DIGITS  = 6;
    localparam int EXP_BIAS  = 1023;

    typedef logic [F_W-1:0] p5_t;
    typedef p5_t            p5_tab_t [0:POW_N-1];
    typedef logic [7:0]     len_tab_t [0:POW_N-1];

    // Builds 5^j shifted up until its leading one sits at the top bit.
    function automatic p5_tab_t gen_pow5();
        p5_tab_t    tab;
        logic [F_W-1:0] x;
        logic [F_W-1:0] v;
        x = {{(F_W-1){1'b0}}, 1'b1};
        for (int j = 0; j < POW_N; j++)
        begin
            v = x;
            for (int b = 0; b < F_W; b++)
            begin
                if (!v[F_W-1])
                begin
                    v = v << 1;
                end
            end
            tab[j] = v;
            x = (x << 2) + x;
        end
        return tab;
    endfunction

    // Bit length of 5^j.
    function automatic len_tab_t gen_len();
        len_tab_t   tab;
        logic [F_W-1:0] x;
        x = {{(F_W-1){1'b0}}, 1'b1};
        for (int j = 0; j < POW_N; j++)
        begin
            tab[j] = 8'd0;
            for (int b = 0; b < F_W; b++)
            begin
                if (x[b])
                begin
                    tab[j] = 8'(b + 1);
                end
            end
            x = (x << 2) + x;
        end
        return tab;
    endfunction

    localparam p5_tab_t  POW5_NORM = gen_pow5();
    localparam len_tab_t POW5_LEN  = gen_len();

    typedef struct packed {
        logic                  valid;
        logic                  neg;
        logic [S_W-1:0]        s;
        logic signed [7:0]     k;
    } dec_stage_t;

    typedef struct packed {
        logic                  valid;
        logic                  neg;
        logic                  zero;
        logic                  is_div;
        logic [S_W-1:0]        s_t;
        logic [F_W-1:0]        f;
        logic signed [E_W-1:0] e;
        logic [P_W-1:0]        acc;
    } mul_stage_t;

    typedef struct packed {
        logic                  valid;
        logic                  neg;
        logic                  zero;
        logic signed [E_W-1:0] e;
        logic [R_W-1:0]        rem;
        logic [P_W-1:0]        den;
        logic [Q_W-1:0]        q;
    } div_stage_t;

endpackage

// ===== sv/bf2b_front.sv =====
`timescale 1ns / 1ps
// Front end: BCD digits to binary, exponent decode, normalization and
// power-of-five table lookup, two register stages. Uses bf2b_pkg.
module bf2b_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [23:0]                 significand_digits,
    input  logic [5:0]                  exponent_magnitude,
    input  logic                        exponent_positive,
    input  logic                        negative,
    output bf2b_pkg::mul_stage_t        mul_out
);

    bf2b_pkg::dec_stage_t dec_reg, dec_next;
    bf2b_pkg::mul_stage_t nrm_reg, nrm_next;

    always_comb
    begin
        logic [bf2b_pkg::S_W-1:0] s;
        logic signed [7:0]        ex;
        s = '0;
        for (int i = 0; i < bf2b_pkg::N_DIGITS; i++)
        begin
            s = (s << 3) + (s << 1)
                + {17'b0, significand_digits[23 - 4*i -: 4]};
        end
        ex = exponent_positive ? $signed({2'b0, exponent_magnitude})
                               : -$signed({2'b0, exponent_magnitude});
        dec_next.valid = in_valid;
        dec_next.neg   = negative;
        dec_next.s     = s;
        dec_next.k     = ex - 8'sd6;
    end

    always_comb
    begin
        logic [4:0]                ls;
        logic [6:0]                j;
        logic [7:0]                l5;
        logic signed [bf2b_pkg::E_W-1:0] ls_s, l5_s, k_s, j_s;
        ls = 5'd0;
        for (int b = 0; b < bf2b_pkg::S_W; b++)
        begin
            if (dec_reg.s[b])
            begin
                ls = 5'(b + 1);
            end
        end
        j  = dec_reg.k[7] ? 7'(-dec_reg.k) : dec_reg.k[6:0];
        l5 = bf2b_pkg::POW5_LEN[j];
        ls_s = $signed({6'b0, ls});
        l5_s = $signed({3'b0, l5});
        k_s  = $signed({{3{dec_reg.k[7]}}, dec_reg.k});
        j_s  = $signed({4'b0, j});
        nrm_next.valid  = dec_reg.valid;
        nrm_next.neg    = dec_reg.neg;
        nrm_next.zero   = (dec_reg.s == '0);
        nrm_next.is_div = dec_reg.k[7];
        nrm_next.s_t    = dec_reg.s << (5'd21 - ls);
        nrm_next.f      = bf2b_pkg::POW5_NORM[j];
        // Mult path: value = Q * 2^(Ls + L5 + k - 56).
        // Divide path: value = Q * 2^(Ls - L5 - 55 - m).
        nrm_next.e      = dec_reg.k[7] ? (ls_s - l5_s - 11'sd55 - j_s)
                                       : (ls_s + l5_s + k_s - 11'sd56);
        nrm_next.acc    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg.valid <= 1'b0;
            nrm_reg.valid <= 1'b0;
        end
        else
        begin
            dec_reg <= dec_next;
            nrm_reg <= nrm_next;
        end
    end

    assign mul_out = nrm_reg;

endmodule

// ===== sv/bf2b_mul.sv =====
`timescale 1ns / 1ps
// Exact shift-and-add multiplier of the significand by 5^k, one significand
// bit per register stage. Uses bf2b_pkg.
module bf2b_mul
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bf2b_pkg::mul_stage_t  mul_in,
    output bf2b_pkg::mul_stage_t  mul_out
);

    bf2b_pkg::mul_stage_t stg [0:bf2b_pkg::MUL_STEPS];

    assign stg[0] = mul_in;

    for (genvar i = 0; i < bf2b_pkg::MUL_STEPS; i++)
    begin : g_step
        bf2b_pkg::mul_stage_t st_reg, st_next;

        always_comb
        begin
            st_next = stg[i];
            if (!stg[i].is_div && stg[i].s_t[i])
            begin
                st_next.acc = stg[i].acc
                    + ({{(bf2b_pkg::P_W - bf2b_pkg::F_W){1'b0}}, stg[i].f} << i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_reg.valid <= 1'b0;
            end
            else
            begin
                st_reg <= st_next;
            end
        end

        assign stg[i+1] = st_reg;
    end

    assign mul_out = stg[bf2b_pkg::MUL_STEPS];

endmodule

// ===== sv/bf2b_div.sv =====
`timescale 1ns / 1ps
// Restoring long division, one quotient bit per register stage. Products
// are divided by a power of two, so both paths share it. Uses bf2b_pkg.
module bf2b_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bf2b_pkg::mul_stage_t  mul_in,
    output bf2b_pkg::div_stage_t  div_out
);

    bf2b_pkg::div_stage_t stg [0:bf2b_pkg::DIV_STEPS];

    always_comb
    begin
        stg[0].valid = mul_in.valid;
        stg[0].neg   = mul_in.neg;
        stg[0].zero  = mul_in.zero;
        stg[0].e     = mul_in.e;
        stg[0].q     = '0;
        if (mul_in.is_div)
        begin
            stg[0].rem = {1'b0, mul_in.s_t, {bf2b_pkg::F_W{1'b0}}};
            stg[0].den = {mul_in.f, {(bf2b_pkg::P_W - bf2b_pkg::F_W){1'b0}}};
        end
        else
        begin
            stg[0].rem = {1'b0, mul_in.acc};
            stg[0].den = {1'b1, {(bf2b_pkg::P_W-1){1'b0}}};
        end
    end

    for (genvar i = 0; i < bf2b_pkg::DIV_STEPS; i++)
    begin : g_step
        bf2b_pkg::div_stage_t st_reg, st_next;

        always_comb
        begin
            logic                     ge;
            logic [bf2b_pkg::R_W-1:0] r1;
            ge = (stg[i].rem >= {1'b0, stg[i].den});
            r1 = ge ? (stg[i].rem - {1'b0, stg[i].den}) : stg[i].rem;
            st_next     = stg[i];
            st_next.rem = r1 << 1;
            st_next.q   = {stg[i].q[bf2b_pkg::Q_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_reg.valid <= 1'b0;
            end
            else
            begin
                st_reg <= st_next;
            end
        end

        assign stg[i+1] = st_reg;
    end

    assign div_out = stg[bf2b_pkg::DIV_STEPS];

endmodule

// ===== sv/bf2b_round.sv =====
`timescale 1ns / 1ps
// Final normalization by one bit, round to nearest even and binary64
// packing into the output register. Uses bf2b_pkg.
module bf2b_round
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bf2b_pkg::div_stage_t  div_in,
    output logic                  done,
    output logic [63:0]           binary64_bits
);

    logic        done_reg;
    logic [63:0] bits_reg, bits_next;

    // The quotient lies in [2^54, 2^56). After the optional one-bit shift, qq
    // holds 53 mantissa bits at [54:2]. Bit 1 is the round bit, and bit 0 joins
    // the sticky bit.
    always_comb
    begin
        logic [54:0]        qq;
        logic               sticky;
        logic [53:0]        mant;
        logic               inc;
        logic signed [11:0] be;
        sticky = (div_in.rem != '0);
        be     = $signed({div_in.e[10], div_in.e}) + 12'sd54 + 12'(bf2b_pkg::EXP_BIAS);
        if (div_in.q[55])
        begin
            qq     = div_in.q[55:1];
            sticky = sticky | div_in.q[0];
            be     = be + 12'sd1;
        end
        else
        begin
            qq = div_in.q[54:0];
        end
        inc  = qq[1] & (sticky | qq[0] | qq[2]);
        mant = {1'b0, qq[54:2]} + {53'b0, inc};
        if (mant[53])
        begin
            mant = mant >> 1;
            be   = be + 12'sd1;
        end
        if (div_in.zero)
        begin
            bits_next = {div_in.neg, 63'b0};
        end
        else
        begin
            bits_next = {div_in.neg, be[10:0], mant[51:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

    assign done          = done_reg;
    assign binary64_bits = bits_reg;

endmodule

// ===== sv/bcd_float_to_binary64.sv =====
`timescale 1ns / 1ps
// Top level of the decimal float to IEEE binary64 converter.
// Instantiates bf2b_front, bf2b_mul, bf2b_div and bf2b_round; uses bf2b_pkg.
//
//  Channel   Handshake         Payload
//  -------   ---------------   ------------------------------------------------
//  request   start, busy       significand_digits, exponent_magnitude,
//                              exponent_positive, negative
//  result    done (strobe)     binary64_bits
//
// A request is taken at every rising edge where start is high; busy is always
// low because the pipeline accepts one request per cycle. Each result passes
// through 2 front stages, 21 multiplier stages, 56 divider stages and the
// rounding register, and appears in request order, with done high for one
// cycle. The latency is set by the one-bit-per-stage multiplier and divider.
// Reset clears only the valid bits; the receiver cannot stall, so nothing
// ever waits inside the pipeline.
//
// The value s * 10^k is kept exact: for k >= 0 it is s * 5^k * 2^k, formed as
// an exact product; for k < 0 it is s / 5^-k * 2^k, formed by long division
// with the remainder kept as the sticky bit. Rounding happens only once.
module bcd_float_to_binary64
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [23:0] significand_digits,
    input  logic [5:0]  exponent_magnitude,
    input  logic        exponent_positive,
    input  logic        negative,
    output logic        done,
    output logic [63:0] binary64_bits
);

    bf2b_pkg::mul_stage_t front_out;
    bf2b_pkg::mul_stage_t mul_out;
    bf2b_pkg::div_stage_t div_out;

    // The pipeline never holds requests off.
    assign busy = 1'b0;

    bf2b_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (start),
        .significand_digits (significand_digits),
        .exponent_magnitude (exponent_magnitude),
        .exponent_positive  (exponent_positive),
        .negative           (negative),
        .mul_out            (front_out)
    );

    bf2b_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .mul_in  (front_out),
        .mul_out (mul_out)
    );

    bf2b_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .mul_in  (mul_out),
        .div_out (div_out)
    );

    bf2b_round u_round
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .div_in        (div_out),
        .done          (done),
        .binary64_bits (binary64_bits)
    );

endmodule

// ===== bench/tb_bcd_float_to_binary64.sv =====
`timescale 1ns / 1ps
// Testbench for bcd_float_to_binary64: drives decimal float requests and checks
// each binary64 result against an exact big-integer conversion. Needs only the RTL.
module tb_bcd_float_to_binary64;

    // Tracks the binary64 patterns that accepted requests must produce, in order.
    class result_board;
        logic [63:0] pending [$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function void note(logic [63:0] bits);
            pending.push_back(bits);
        endfunction

        function void check(logic [63:0] actual);
            logic [63:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with no request pending, actual %h", $time, actual);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (want !== actual)
                begin
                    $display("%0t: binary64_bits mismatch, expected %h actual %h",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    localparam int N_ITEMS    = 750;
    localparam int QUIET_TAIL = 100;   // the last requests go out without gaps
    localparam int LATENCY    = 80;
    localparam int MAX_CYCLES = 200000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [23:0] significand_digits;
    logic [5:0]  exponent_magnitude;
    logic        exponent_positive;
    logic        negative;
    logic        done;
    logic [63:0] binary64_bits;

    result_board board;
    int          sent;
    int          gap;
    int          cycles;
    int          n_dir;
    logic [31:0] dir_items [$];   // {negative, exponent_positive, magnitude, digits}

    bcd_float_to_binary64 DUT
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .significand_digits (significand_digits),
        .exponent_magnitude (exponent_magnitude),
        .exponent_positive  (exponent_positive),
        .negative           (negative),
        .done               (done),
        .binary64_bits      (binary64_bits)
    );

    always #1 clk = ~clk;

    function automatic int bit_length(logic [319:0] x);
        int n;
        n = 0;
        for (int b = 0; b < 320; b++)
        begin
            if (x[b])
            begin
                n = b + 1;
            end
        end
        return n;
    endfunction

    // Exact conversion: the value is kept as the ratio num / den of integers, the
    // quotient is taken to 55 bits plus a sticky bit, and rounding happens once.
    function automatic logic [63:0] to_binary64(logic [23:0] dg, logic [5:0] mag,
                                                 logic pos, logic neg);
        logic [319:0] num;
        logic [319:0] den;
        logic [319:0] dv;
        logic [55:0]  q;
        logic [53:0]  mant;
        logic         sticky;
        int           s;
        int           k;
        int           t;
        int           e;
        s = 0;
        // Nibbles above nine keep their face value as the digit weight.
        for (int i = 0; i < 6; i++)
        begin
            s = s * 10 + dg[20 - 4 * i +: 4];
        end
        if (s == 0)
        begin
            return {neg, 63'b0};
        end
        k = (pos ? int'(mag) : -int'(mag)) - 6;
        num = 320'(s);
        den = 320'd1;
        for (int i = 0; i < (k > 0 ? k : -k); i++)
        begin
            if (k > 0)
            begin
                num = num * 10;
            end
            else
            begin
                den = den * 10;
            end
        end
        t = 54 - (bit_length(num) - bit_length(den));
        if (t >= 0)
        begin
            num = num << t;
        end
        else
        begin
            den = den << (-t);
        end
        dv = den << 54;
        q = '0;
        for (int i = 54; i >= 0; i--)
        begin
            if (num >= dv)
            begin
                num = num - dv;
                q[i] = 1'b1;
            end
            dv = dv >> 1;
        end
        sticky = (num != 0);
        if (q[54])
        begin
            sticky = sticky | q[0];
            q = q >> 1;
            t = t - 1;
        end
        e = 53 - t;
        mant = {1'b0, q[53:1]};
        if (q[0] && (sticky || mant[0]))
        begin
            mant = mant + 1;
        end
        if (mant[53])
        begin
            mant = mant >> 1;
            e = e + 1;
        end
        return {neg, 11'(e + 1023), mant[51:0]};
    endfunction

    // Random digits: mostly proper decimal digits, sometimes any nibble, now and
    // then a zero significand.
    function automatic logic [23:0] random_digits();
        logic [23:0] d;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            d = '0;
        end
        else if (pick < 4)
        begin
            d = 24'($urandom);
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                d[4 * i +: 4] = 4'($urandom_range(0, 9));
            end
        end
        return d;
    endfunction

    // Driver and request monitor in one process, so that acceptance and the next
    // drive decision both use the values seen just before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (start && !busy)
            begin
                board.note(to_binary64(significand_digits, exponent_magnitude,
                                       exponent_positive, negative));
                sent = sent + 1;
                // Occasional bursts of idle cycles, none near the end.
                if (sent < N_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
                begin
                    gap = $urandom_range(1, 15);
                end
            end
            if (start && busy)
            begin
                // The request stays on the ports until it is taken.
            end
            else if (gap > 0 || sent >= N_ITEMS)
            begin
                start <= 1'b0;
                if (gap > 0)
                begin
                    gap = gap - 1;
                end
            end
            else if (sent < n_dir)
            begin
                start              <= 1'b1;
                significand_digits <= dir_items[sent][23:0];
                exponent_magnitude <= dir_items[sent][29:24];
                exponent_positive  <= dir_items[sent][30];
                negative           <= dir_items[sent][31];
            end
            else
            begin
                start              <= 1'b1;
                significand_digits <= random_digits();
                exponent_magnitude <= ($urandom_range(0, 7) == 0) ?
                                      ($urandom_range(0, 1) ? 6'd63 : 6'd0) :
                                      6'($urandom_range(0, 63));
                exponent_positive  <= 1'($urandom);
                negative           <= 1'($urandom);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            board.check(binary64_bits);
        end
        if (cycles > MAX_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        significand_digits = '0;
        exponent_magnitude = '0;
        exponent_positive = 1'b0;
        negative = 1'b0;
        sent = 0;
        gap = 0;
        cycles = 0;
        // Directed requests: field extremes, zero of both signs, a negative zero
        // exponent, nibbles above nine, and the smallest and largest magnitudes.
        dir_items.push_back({1'b0, 1'b1, 6'd0,  24'h999999});
        dir_items.push_back({1'b1, 1'b1, 6'd0,  24'hFFFFFF});
        dir_items.push_back({1'b0, 1'b0, 6'd0,  24'h000001});
        dir_items.push_back({1'b0, 1'b1, 6'd5,  24'h000000});
        dir_items.push_back({1'b1, 1'b0, 6'd63, 24'h000000});
        dir_items.push_back({1'b0, 1'b1, 6'd63, 24'hFFFFFF});
        dir_items.push_back({1'b1, 1'b1, 6'd63, 24'h999999});
        dir_items.push_back({1'b0, 1'b0, 6'd63, 24'h000001});
        dir_items.push_back({1'b1, 1'b0, 6'd63, 24'h100000});
        dir_items.push_back({1'b0, 1'b1, 6'd1,  24'h100000});
        dir_items.push_back({1'b0, 1'b0, 6'd1,  24'h500000});
        dir_items.push_back({1'b1, 1'b1, 6'd6,  24'h123456});
        dir_items.push_back({1'b0, 1'b0, 6'd32, 24'hA0F0B0});
        dir_items.push_back({1'b0, 1'b1, 6'd17, 24'h250000});
        dir_items.push_back({1'b1, 1'b0, 6'd22, 24'h333333});
        dir_items.push_back({1'b0, 1'b1, 6'd42, 24'h0F0F0F});
        dir_items.push_back({1'b0, 1'b1, 6'd23, 24'h900719});
        dir_items.push_back({1'b1, 1'b0, 6'd1,  24'h000005});
        n_dir = dir_items.size();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (sent >= N_ITEMS);
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 20) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
